FILE: design/snfcs_pkg.sv
package snfcs_pkg;

  localparam int MaxResults = 6;
  localparam int CountW = 3;

  localparam int SectorBytes = 4096;
  localparam int BlockBytes = 65536;
  localparam int MaxReadLen = 65536;

  localparam logic [3:0] REQ_ID = 4'd0;
  localparam logic [3:0] REQ_WREN = 4'd1;
  localparam logic [3:0] REQ_WRDIS = 4'd2;
  localparam logic [3:0] REQ_SECTOR_ERASE = 4'd3;
  localparam logic [3:0] REQ_BLOCK_ERASE = 4'd4;
  localparam logic [3:0] REQ_CHIP_ERASE = 4'd5;
  localparam logic [3:0] REQ_READ = 4'd6;
  localparam logic [3:0] REQ_PROG_BEGIN = 4'd7;
  localparam logic [3:0] REQ_PROG_DATA = 4'd8;
  localparam logic [3:0] REQ_REPLY = 4'd9;

  localparam logic [2:0] K_SPI = 3'd0;
  localparam logic [2:0] K_READ = 3'd1;
  localparam logic [2:0] K_ID = 3'd2;
  localparam logic [2:0] K_DONE = 3'd3;
  localparam logic [2:0] K_REJECT = 3'd4;

  localparam logic [7:0] OP_READ_ID = 8'h90;
  localparam logic [7:0] OP_WREN = 8'h06;
  localparam logic [7:0] OP_WRDI = 8'h04;
  localparam logic [7:0] OP_RDSR = 8'h05;
  localparam logic [7:0] OP_PROGRAM = 8'h02;
  localparam logic [7:0] OP_READ = 8'h03;
  localparam logic [7:0] OP_SECTOR_ERASE = 8'h20;
  localparam logic [7:0] OP_BLOCK_ERASE = 8'hD8;
  localparam logic [7:0] OP_CHIP_ERASE = 8'hC7;
  localparam logic [7:0] DUMMY_BYTE = 8'hFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  mosi_byte;
    logic        frame_end;
    logic        wants_reply;
    logic [7:0]  read_byte;
    logic [15:0] device_id;
  } entry_t;

  typedef struct packed {
    entry_t [MaxResults-1:0] ent;
    logic [CountW-1:0]       count;
  } batch_t;

  function automatic entry_t spi_e(logic [7:0] b, logic fend, logic want);
    entry_t e;
    e = '0;
    e.kind = K_SPI;
    e.mosi_byte = b;
    e.frame_end = fend;
    e.wants_reply = want;
    return e;
  endfunction

  function automatic entry_t info_e(logic [2:0] k, logic [7:0] rbyte, logic [15:0] dev);
    entry_t e;
    e = '0;
    e.kind = k;
    e.read_byte = rbyte;
    e.device_id = dev;
    return e;
  endfunction

endpackage

FILE: design/snfcs_if.sv
interface snfcs_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [23:0] byte_address;
  logic [9:0]  unit_index;
  logic [16:0] read_length;
  logic [7:0]  data_byte;
  logic        data_last;
  logic [7:0]  reply_byte;

  modport source (
    output valid, req_type, byte_address, unit_index, read_length,
           data_byte, data_last, reply_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, byte_address, unit_index, read_length,
           data_byte, data_last, reply_byte,
    output ready
  );
endinterface

interface snfcs_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  mosi_byte;
  logic        frame_end;
  logic        wants_reply;
  logic [7:0]  read_byte;
  logic [15:0] device_id;
  logic        last;

  modport source (
    output valid, kind, mosi_byte, frame_end, wants_reply, read_byte,
           device_id, last,
    input  ready
  );
  modport sink (
    input  valid, kind, mosi_byte, frame_end, wants_reply, read_byte,
           device_id, last,
    output ready
  );
endinterface

FILE: design/snfcs_result_queue.sv
module snfcs_result_queue
  import snfcs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  batch_t       batch,
  output logic         can_load,
  snfcs_rsp_if.source  rsp
);

  entry_t              ent [MaxResults];
  logic [CountW-1:0]   n;
  logic [CountW-1:0]   rd;
  logic                busy;
  logic                at_last;
  logic                drain;

  assign at_last = (rd == n - CountW'(1));
  assign drain = busy && rsp.ready;
  assign can_load = !busy || (rsp.ready && at_last);

  assign rsp.valid = busy;
  assign rsp.kind = ent[rd].kind;
  assign rsp.mosi_byte = ent[rd].mosi_byte;
  assign rsp.frame_end = ent[rd].frame_end;
  assign rsp.wants_reply = ent[rd].wants_reply;
  assign rsp.read_byte = ent[rd].read_byte;
  assign rsp.device_id = ent[rd].device_id;
  assign rsp.last = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rd <= '0;
      n <= '0;
    end else if (load) begin
      for (int i = 0; i < MaxResults; i++) begin
        ent[i] <= batch.ent[i];
      end
      n <= batch.count;
      rd <= '0;
      busy <= (batch.count != '0);
    end else if (drain) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        rd <= rd + CountW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rd < n))
    else $error("read pointer beyond the stored results");
  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready && rsp.last && !load) |=> !rsp.valid)
    else $error("results still shown after the final transfer");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (load && busy) |-> (rsp.ready && at_last))
    else $error("new batch overwrote undelivered results");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid)
    else $error("results shown right after reset");
`endif

endmodule

FILE: design/spi_nor_flash_command_sequencer.sv
// Channel  Direction  Transfer carries
// req      in         one request or one reply byte from the flash
// rsp      out        one result: SPI byte, read data, device ID, done or rejected
//
// Each accepted item is decoded in the cycle of its transfer into up to six
// results, which a result buffer hands out one per cycle while the output is ready.
// An item is taken when the buffer is empty, or in the cycle the previous
// item's last result transfers.
// Reset is synchronous and returns the sequencer to idle with an empty buffer.
// A stalled output holds the buffer, and with it the request side.
module spi_nor_flash_command_sequencer
  import snfcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  snfcs_req_if.sink   req,
  snfcs_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ID_HIGH,
    PH_ID_LOW,
    PH_POLL_PRE,
    PH_POLL_POST,
    PH_READ,
    PH_PROG_DATA
  } phase_t;

  localparam logic [24:0] MaxLen = 25'(MaxReadLen);

  phase_t      phase, phase_next;
  logic [3:0]  operation, operation_next;
  logic [23:0] target_address, target_address_next;
  logic [16:0] bytes_left, bytes_left_next;
  logic [7:0]  id_high, id_high_next;

  batch_t      batch_next;
  logic        can_load;
  logic        accept;
  logic [30:0] sector_prod;
  logic [30:0] block_prod;
  logic [16:0] left_dec;
  logic        len_bad;

  assign req.ready = can_load;
  assign accept = req.valid && req.ready;

  assign sector_prod = 31'(req.unit_index) * 31'(SectorBytes);
  assign block_prod = 31'(req.unit_index) * 31'(BlockBytes);
  assign left_dec = bytes_left - 17'd1;
  assign len_bad = (req.read_length == '0) || ({8'd0, req.read_length} > MaxLen);

  always_comb begin
    logic reject;
    reject = 1'b0;
    batch_next = '0;
    phase_next = phase;
    operation_next = operation;
    target_address_next = target_address;
    bytes_left_next = bytes_left;
    id_high_next = id_high;

    if (req.req_type == REQ_REPLY) begin
      unique case (phase)
        PH_ID_HIGH: begin
          id_high_next = req.reply_byte;
          batch_next.ent[0] = spi_e(DUMMY_BYTE, 1'b1, 1'b1);
          batch_next.count = CountW'(1);
          phase_next = PH_ID_LOW;
        end
        PH_ID_LOW: begin
          batch_next.ent[0] = info_e(K_ID, 8'd0, {id_high, req.reply_byte});
          batch_next.count = CountW'(1);
          phase_next = PH_IDLE;
        end
        PH_POLL_PRE: begin
          if (req.reply_byte[0]) begin
            batch_next.ent[0] = spi_e(OP_RDSR, 1'b0, 1'b0);
            batch_next.ent[1] = spi_e(DUMMY_BYTE, 1'b1, 1'b1);
            batch_next.count = CountW'(2);
          end else if (operation == REQ_SECTOR_ERASE || operation == REQ_BLOCK_ERASE) begin
            batch_next.ent[0] = spi_e((operation == REQ_SECTOR_ERASE) ?
                                      OP_SECTOR_ERASE : OP_BLOCK_ERASE, 1'b0, 1'b0);
            batch_next.ent[1] = spi_e(target_address[23:16], 1'b0, 1'b0);
            batch_next.ent[2] = spi_e(target_address[15:8], 1'b0, 1'b0);
            batch_next.ent[3] = spi_e(target_address[7:0], 1'b1, 1'b0);
            batch_next.ent[4] = spi_e(OP_RDSR, 1'b0, 1'b0);
            batch_next.ent[5] = spi_e(DUMMY_BYTE, 1'b1, 1'b1);
            batch_next.count = CountW'(6);
            phase_next = PH_POLL_POST;
          end else if (operation == REQ_CHIP_ERASE) begin
            batch_next.ent[0] = spi_e(OP_CHIP_ERASE, 1'b1, 1'b0);
            batch_next.ent[1] = spi_e(OP_RDSR, 1'b0, 1'b0);
            batch_next.ent[2] = spi_e(DUMMY_BYTE, 1'b1, 1'b1);
            batch_next.count = CountW'(3);
            phase_next = PH_POLL_POST;
          end else begin
            batch_next.ent[0] = spi_e(OP_PROGRAM, 1'b0, 1'b0);
            batch_next.ent[1] = spi_e(target_address[23:16], 1'b0, 1'b0);
            batch_next.ent[2] = spi_e(target_address[15:8], 1'b0, 1'b0);
            batch_next.ent[3] = spi_e(target_address[7:0], 1'b0, 1'b0);
            batch_next.count = CountW'(4);
            phase_next = PH_PROG_DATA;
          end
        end
        PH_POLL_POST: begin
          if (req.reply_byte[0]) begin
            batch_next.ent[0] = spi_e(OP_RDSR, 1'b0, 1'b0);
            batch_next.ent[1] = spi_e(DUMMY_BYTE, 1'b1, 1'b1);
            batch_next.count = CountW'(2);
          end else begin
            batch_next.ent[0] = info_e(K_DONE, 8'd0, 16'd0);
            batch_next.count = CountW'(1);
            phase_next = PH_IDLE;
          end
        end
        PH_READ: begin
          bytes_left_next = left_dec;
          batch_next.ent[0] = info_e(K_READ, req.reply_byte, 16'd0);
          if (left_dec != '0) begin
            batch_next.ent[1] = spi_e(DUMMY_BYTE, left_dec == 17'd1, 1'b1);
          end else begin
            batch_next.ent[1] = info_e(K_DONE, 8'd0, 16'd0);
            phase_next = PH_IDLE;
          end
          batch_next.count = CountW'(2);
        end
        default: begin
          reject = 1'b1;
        end
      endcase
    end else if (req.req_type == REQ_PROG_DATA) begin
      if (phase == PH_PROG_DATA) begin
        batch_next.ent[0] = spi_e(req.data_byte, req.data_last, 1'b0);
        if (req.data_last) begin
          batch_next.ent[1] = spi_e(OP_RDSR, 1'b0, 1'b0);
          batch_next.ent[2] = spi_e(DUMMY_BYTE, 1'b1, 1'b1);
          batch_next.count = CountW'(3);
          phase_next = PH_POLL_POST;
        end else begin
          batch_next.count = CountW'(1);
        end
      end else begin
        reject = 1'b1;
      end
    end else if (phase != PH_IDLE || req.req_type > REQ_REPLY) begin
      reject = 1'b1;
    end else begin
      unique case (req.req_type)
        REQ_ID: begin
          batch_next.ent[0] = spi_e(OP_READ_ID, 1'b0, 1'b0);
          batch_next.ent[1] = spi_e(8'd0, 1'b0, 1'b0);
          batch_next.ent[2] = spi_e(8'd0, 1'b0, 1'b0);
          batch_next.ent[3] = spi_e(8'd0, 1'b0, 1'b0);
          batch_next.ent[4] = spi_e(DUMMY_BYTE, 1'b0, 1'b1);
          batch_next.count = CountW'(5);
          operation_next = REQ_ID;
          phase_next = PH_ID_HIGH;
        end
        REQ_WREN, REQ_WRDIS: begin
          batch_next.ent[0] = spi_e((req.req_type == REQ_WREN) ? OP_WREN : OP_WRDI,
                                    1'b1, 1'b0);
          batch_next.ent[1] = info_e(K_DONE, 8'd0, 16'd0);
          batch_next.count = CountW'(2);
        end
        REQ_READ: begin
          if (len_bad) begin
            reject = 1'b1;
          end else begin
            operation_next = REQ_READ;
            target_address_next = req.byte_address;
            bytes_left_next = req.read_length;
            batch_next.ent[0] = spi_e(OP_READ, 1'b0, 1'b0);
            batch_next.ent[1] = spi_e(req.byte_address[23:16], 1'b0, 1'b0);
            batch_next.ent[2] = spi_e(req.byte_address[15:8], 1'b0, 1'b0);
            batch_next.ent[3] = spi_e(req.byte_address[7:0], 1'b0, 1'b0);
            batch_next.ent[4] = spi_e(DUMMY_BYTE, req.read_length == 17'd1, 1'b1);
            batch_next.count = CountW'(5);
            phase_next = PH_READ;
          end
        end
        default: begin
          // Erase and program begin: write enable, then poll until ready.
          operation_next = req.req_type;
          unique case (req.req_type)
            REQ_SECTOR_ERASE: target_address_next = sector_prod[23:0];
            REQ_BLOCK_ERASE:  target_address_next = block_prod[23:0];
            REQ_CHIP_ERASE:   target_address_next = 24'd0;
            default:          target_address_next = req.byte_address;
          endcase
          batch_next.ent[0] = spi_e(OP_WREN, 1'b1, 1'b0);
          batch_next.ent[1] = spi_e(OP_RDSR, 1'b0, 1'b0);
          batch_next.ent[2] = spi_e(DUMMY_BYTE, 1'b1, 1'b1);
          batch_next.count = CountW'(3);
          phase_next = PH_POLL_PRE;
        end
      endcase
    end

    if (reject) begin
      batch_next = '0;
      batch_next.ent[0] = info_e(K_REJECT, 8'd0, 16'd0);
      batch_next.count = CountW'(1);
      phase_next = phase;
      operation_next = operation;
      target_address_next = target_address;
      bytes_left_next = bytes_left;
      id_high_next = id_high;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      operation <= '0;
      target_address <= '0;
      bytes_left <= '0;
      id_high <= '0;
    end else if (accept) begin
      phase <= phase_next;
      operation <= operation_next;
      target_address <= target_address_next;
      bytes_left <= bytes_left_next;
      id_high <= id_high_next;
    end
  end

  snfcs_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .batch    (batch_next),
    .can_load (can_load),
    .rsp      (rsp)
  );

`ifndef NO_ASSERTIONS
  a_batch_size: assert property (@(posedge clk) disable iff (rst)
    accept |-> (batch_next.count != '0 && batch_next.count <= CountW'(MaxResults)))
    else $error("accepted item produced no results or too many");
  a_read_counts: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_READ) |-> (bytes_left != '0))
    else $error("read phase with no bytes left");
  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && batch_next.ent[0].kind == K_REJECT) |=> $stable(phase))
    else $error("rejected item changed the sequencer phase");
`endif

endmodule
